// ===== sv/bbcc_pkg.sv =====
// bbcc_pkg: shared types and codes for the buffer cache clock policy core
// no dependencies; used by the tag store, the top level and the testbench
`default_nettype none

package bbcc_pkg;

  // request modes
  localparam logic [2:0] MODE_GET     = 3'd0;
  localparam logic [2:0] MODE_NEW     = 3'd1;
  localparam logic [2:0] MODE_RELEASE = 3'd2;
  localparam logic [2:0] MODE_DIRTY   = 3'd3;
  localparam logic [2:0] MODE_RENAME  = 3'd4;
  localparam logic [2:0] MODE_SYNC    = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_WBACK = 2'd1;
  localparam logic [1:0] KIND_FILL  = 2'd2;
  localparam logic [1:0] KIND_ZERO  = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_MISS       = 3'd1;
  localparam logic [2:0] STAT_BLOCK_ZERO = 3'd2;
  localparam logic [2:0] STAT_ALL_PINNED = 3'd3;
  localparam logic [2:0] STAT_UNPINNED   = 3'd4;

  // pin count limits
  localparam logic signed [7:0] PIN_MAX   = 8'sd127;
  localparam logic signed [7:0] PIN_SPENT = -8'sd1;

  // sweep gives up on the wrap of the hand after this many wraps
  localparam logic [1:0] WRAP_LIMIT = 2'd2;

  typedef struct packed {
    logic [7:0]  device;
    logic [31:0] block;
  } tag_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  slot;
    logic [7:0]  device;
    logic [31:0] block;
    logic [2:0]  status;
    logic        last;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND_RD,
    S_FIND_CMP,
    S_REN_SET,
    S_SWEEP,
    S_SWEEP_TEST,
    S_VICTIM,
    S_SLOT_RD,
    S_SLOT_OP,
    S_SYNC_RD,
    S_SYNC_CMP,
    S_SYNC_NEXT,
    S_PEND_LOAD,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== sv/bbcc_if.sv =====
// bbcc_req_if / bbcc_rsp_if: valid-ready channels for requests and results
// no dependencies
`default_nettype none

interface bbcc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [7:0]  device;
  logic [31:0] block_number;
  logic [4:0]  buffer_slot;

  modport source (output valid, mode, device, block_number, buffer_slot, input ready);
  modport sink   (input valid, mode, device, block_number, buffer_slot, output ready);
endinterface

interface bbcc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  slot;
  logic [7:0]  out_device;
  logic [31:0] out_block;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, kind, slot, out_device, out_block, status, last,
                  input ready);
  modport sink   (input valid, kind, slot, out_device, out_block, status, last,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/bbcc_tag_store.sv =====
// bbcc_tag_store: device/block tag memory, one address per cycle, registered read
// depends on bbcc_pkg; entries never written read back as zero
`default_nettype none

module bbcc_tag_store #(
  parameter int NUM_BUFFERS = 31
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [$clog2(NUM_BUFFERS)-1:0] addr,
  input  wire logic                           wr_en,
  input  wire bbcc_pkg::tag_t                 wr_data,
  output bbcc_pkg::tag_t                      rd_data
);

  bbcc_pkg::tag_t           mem [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0]   written;
  bbcc_pkg::tag_t           rd_q;
  logic                     rd_written;

  // written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[addr] <= 1'b1;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_q       <= mem[addr];
    rd_written <= written[addr];
  end

  assign rd_data = rd_written ? rd_q : '0;

endmodule

`default_nettype wire

// ===== sv/block_buffer_cache_clock_policy_core.sv =====
// Buffer cache tag, pin and clock replacement engine; one request at a time.
// A lookup walks the entries in turn, reading each tag and then comparing it; a sync
// walk reads, compares and steps on for each entry; the sweep steps the hand and then
// tests the pin count, over up to three wraps; each result passes through the emit state.
// req.ready is high only when idle; a request waits until the last result is registered.
// Reset: synchronous; clears valid, dirty, pin counts, hand and the output valid flag.
`default_nettype none

module block_buffer_cache_clock_policy_core #(
  parameter int NUM_BUFFERS = 31
) (
  input wire logic    clk,
  input wire logic    rst,
  bbcc_req_if.sink    req,
  bbcc_rsp_if.source  rsp
);

  localparam int IW = $clog2(NUM_BUFFERS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUFFERS - 1);

  bbcc_pkg::state_t state, state_next, ret, ret_next;

  // latched request
  logic [2:0]  cur_mode;
  logic [7:0]  cur_dev;
  logic [31:0] cur_blk;
  logic [4:0]  cur_slot;

  logic [IW-1:0] idx, idx_next;
  logic [IW-1:0] hand, hand_next;
  logic [1:0]    wraps, wraps_next;
  logic          have_pend, have_pend_next;
  bbcc_pkg::res_t res, res_next, pend, pend_next, out_q;
  logic          out_valid;

  // per-entry state
  logic [NUM_BUFFERS-1:0] valid;
  logic [NUM_BUFFERS-1:0] dirty;
  logic signed [7:0]      pins [NUM_BUFFERS];

  // array writes, all at idx
  logic              pin_we, valid_we, valid_wd, dirty_we, dirty_wd, tag_we;
  logic signed [7:0] pin_wd;
  bbcc_pkg::tag_t    tag_q;

  logic signed [7:0] p;
  logic              v, d, obuf_free, slot_oor, hit;
  logic [IW:0]       hand_inc;
  logic signed [7:0] p_up, p_down;

  bbcc_tag_store #(.NUM_BUFFERS(NUM_BUFFERS)) u_tags (
    .clk     (clk),
    .rst     (rst),
    .addr    (idx),
    .wr_en   (tag_we),
    .wr_data ({cur_dev, cur_blk}),
    .rd_data (tag_q)
  );

  assign p         = pins[idx];
  assign v         = valid[idx];
  assign d         = dirty[idx];
  assign obuf_free = !out_valid || rsp.ready;
  assign slot_oor  = {2'b00, cur_slot} >= 7'(NUM_BUFFERS);
  assign hit       = v && (tag_q.device == cur_dev) && (tag_q.block == cur_blk);
  assign hand_inc  = {1'b0, hand} + 1'b1;
  assign p_up      = (p < 0) ? 8'sd1 : ((p < bbcc_pkg::PIN_MAX) ? p + 8'sd1 : p);
  assign p_down    = (p > bbcc_pkg::PIN_SPENT) ? p - 8'sd1 : p;

  assign req.ready = (state == bbcc_pkg::S_IDLE);

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bbcc_pkg::S_IDLE;
      ret       <= bbcc_pkg::S_IDLE;
      hand      <= '0;
      wraps     <= '0;
      have_pend <= 1'b0;
      idx       <= '0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      hand      <= hand_next;
      wraps     <= wraps_next;
      have_pend <= have_pend_next;
      idx       <= idx_next;
    end
    res  <= res_next;
    pend <= pend_next;
    if (req.valid && req.ready) begin
      cur_mode <= req.mode;
      cur_dev  <= req.device;
      cur_blk  <= req.block_number;
      cur_slot <= req.buffer_slot;
    end
  end

  // entry flags and pin counts
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      dirty <= '0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        pins[i] <= 8'sd0;
      end
    end else begin
      if (valid_we) valid[idx] <= valid_wd;
      if (dirty_we) dirty[idx] <= dirty_wd;
      if (pin_we)   pins[idx]  <= pin_wd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == bbcc_pkg::S_EMIT && obuf_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (state == bbcc_pkg::S_EMIT && obuf_free) begin
      out_q <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.kind       = out_q.kind;
  assign rsp.slot       = out_q.slot;
  assign rsp.out_device = out_q.device;
  assign rsp.out_block  = out_q.block;
  assign rsp.status     = out_q.status;
  assign rsp.last       = out_q.last;

  // sequencer
  always_comb begin
    state_next     = state;
    ret_next       = ret;
    idx_next       = idx;
    hand_next      = hand;
    wraps_next     = wraps;
    have_pend_next = have_pend;
    res_next       = res;
    pend_next      = pend;
    pin_we         = 1'b0;
    pin_wd         = p;
    valid_we       = 1'b0;
    valid_wd       = 1'b0;
    dirty_we       = 1'b0;
    dirty_wd       = 1'b0;
    tag_we         = 1'b0;
    unique case (state)
      bbcc_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = bbcc_pkg::S_DISPATCH;
        end
      end
      bbcc_pkg::S_DISPATCH: begin
        res_next   = '{bbcc_pkg::KIND_DONE, 5'd0, 8'd0, 32'd0, bbcc_pkg::STAT_OK, 1'b1};
        ret_next   = bbcc_pkg::S_IDLE;
        state_next = bbcc_pkg::S_EMIT;
        case (cur_mode) inside
          bbcc_pkg::MODE_GET, bbcc_pkg::MODE_NEW: begin
            wraps_next = '0;
            if (cur_blk == 32'd0) begin
              res_next.status = bbcc_pkg::STAT_BLOCK_ZERO;
            end else begin
              idx_next   = '0;
              state_next = bbcc_pkg::S_FIND_RD;
            end
          end
          bbcc_pkg::MODE_RELEASE, bbcc_pkg::MODE_DIRTY: begin
            if (!slot_oor) begin
              idx_next   = IW'(cur_slot);
              state_next = bbcc_pkg::S_SLOT_RD;
            end
          end
          bbcc_pkg::MODE_RENAME: begin
            if (!slot_oor) begin
              idx_next   = '0;
              state_next = bbcc_pkg::S_FIND_RD;
            end
          end
          bbcc_pkg::MODE_SYNC: begin
            idx_next       = '0;
            have_pend_next = 1'b0;
            state_next     = bbcc_pkg::S_SYNC_RD;
          end
          default: begin
          end
        endcase
      end
      bbcc_pkg::S_FIND_RD: begin
        state_next = bbcc_pkg::S_FIND_CMP;
      end
      bbcc_pkg::S_FIND_CMP: begin
        if (hit) begin
          if (cur_mode == bbcc_pkg::MODE_RENAME) begin
            valid_we   = 1'b1;
            valid_wd   = 1'b0;
            pin_we     = 1'b1;
            pin_wd     = 8'sd0;
            idx_next   = IW'(cur_slot);
            state_next = bbcc_pkg::S_REN_SET;
          end else begin
            pin_we   = 1'b1;
            pin_wd   = p_up;
            ret_next = bbcc_pkg::S_IDLE;
            if (cur_mode == bbcc_pkg::MODE_NEW) begin
              dirty_we = 1'b1;
              dirty_wd = 1'b1;
              res_next = '{bbcc_pkg::KIND_ZERO, 5'(idx), cur_dev, cur_blk,
                           bbcc_pkg::STAT_OK, 1'b1};
            end else begin
              res_next = '{bbcc_pkg::KIND_DONE, 5'(idx), 8'd0, 32'd0,
                           bbcc_pkg::STAT_OK, 1'b1};
            end
            state_next = bbcc_pkg::S_EMIT;
          end
        end else if (idx == LAST_IDX) begin
          if (cur_mode == bbcc_pkg::MODE_RENAME) begin
            idx_next   = IW'(cur_slot);
            state_next = bbcc_pkg::S_REN_SET;
          end else begin
            state_next = bbcc_pkg::S_SWEEP;
          end
        end else begin
          idx_next   = idx + 1'b1;
          state_next = bbcc_pkg::S_FIND_RD;
        end
      end
      bbcc_pkg::S_REN_SET: begin
        valid_we   = 1'b1;
        valid_wd   = 1'b1;
        dirty_we   = 1'b1;
        dirty_wd   = 1'b1;
        tag_we     = 1'b1;
        pin_we     = 1'b1;
        pin_wd     = p_down;
        res_next   = '{bbcc_pkg::KIND_DONE, cur_slot, 8'd0, 32'd0, bbcc_pkg::STAT_OK, 1'b1};
        ret_next   = bbcc_pkg::S_IDLE;
        state_next = bbcc_pkg::S_EMIT;
      end
      bbcc_pkg::S_SWEEP: begin
        // advance the hand, counting wraps
        if (hand_inc >= (IW+1)'(NUM_BUFFERS)) begin
          hand_next = '0;
          idx_next  = '0;
          if (wraps == bbcc_pkg::WRAP_LIMIT) begin
            res_next   = '{bbcc_pkg::KIND_DONE, 5'd0, 8'd0, 32'd0,
                           bbcc_pkg::STAT_ALL_PINNED, 1'b1};
            ret_next   = bbcc_pkg::S_IDLE;
            state_next = bbcc_pkg::S_EMIT;
          end else begin
            wraps_next = wraps + 1'b1;
            state_next = bbcc_pkg::S_SWEEP_TEST;
          end
        end else begin
          hand_next  = hand_inc[IW-1:0];
          idx_next   = hand_inc[IW-1:0];
          state_next = bbcc_pkg::S_SWEEP_TEST;
        end
      end
      bbcc_pkg::S_SWEEP_TEST: begin
        if (p < 0) begin
          state_next = bbcc_pkg::S_VICTIM;
        end else begin
          if (p == 8'sd0) begin
            pin_we = 1'b1;
            pin_wd = bbcc_pkg::PIN_SPENT;
          end
          state_next = bbcc_pkg::S_SWEEP;
        end
      end
      bbcc_pkg::S_VICTIM: begin
        // take the victim and install the new name
        pin_we    = 1'b1;
        pin_wd    = 8'sd1;
        valid_we  = 1'b1;
        valid_wd  = 1'b1;
        dirty_we  = 1'b1;
        dirty_wd  = (cur_mode == bbcc_pkg::MODE_NEW);
        tag_we    = 1'b1;
        pend_next = '{(cur_mode == bbcc_pkg::MODE_GET) ? bbcc_pkg::KIND_FILL
                                                        : bbcc_pkg::KIND_ZERO,
                      5'(idx), cur_dev, cur_blk, bbcc_pkg::STAT_MISS, 1'b1};
        if (d) begin
          res_next = '{bbcc_pkg::KIND_WBACK, 5'(idx), tag_q.device, tag_q.block,
                       bbcc_pkg::STAT_OK, 1'b0};
          ret_next = bbcc_pkg::S_PEND_LOAD;
        end else begin
          res_next = '{(cur_mode == bbcc_pkg::MODE_GET) ? bbcc_pkg::KIND_FILL
                                                         : bbcc_pkg::KIND_ZERO,
                       5'(idx), cur_dev, cur_blk, bbcc_pkg::STAT_MISS, 1'b1};
          ret_next = bbcc_pkg::S_IDLE;
        end
        state_next = bbcc_pkg::S_EMIT;
      end
      bbcc_pkg::S_PEND_LOAD: begin
        res_next   = pend;
        ret_next   = bbcc_pkg::S_IDLE;
        state_next = bbcc_pkg::S_EMIT;
      end
      bbcc_pkg::S_SLOT_RD: begin
        state_next = bbcc_pkg::S_SLOT_OP;
      end
      bbcc_pkg::S_SLOT_OP: begin
        res_next   = '{bbcc_pkg::KIND_DONE, cur_slot, 8'd0, 32'd0, bbcc_pkg::STAT_OK, 1'b1};
        ret_next   = bbcc_pkg::S_IDLE;
        state_next = bbcc_pkg::S_EMIT;
        if (cur_mode == bbcc_pkg::MODE_RELEASE) begin
          if (p <= 0) begin
            res_next.status = bbcc_pkg::STAT_UNPINNED;
          end else begin
            pin_we = 1'b1;
            pin_wd = p_down;
            if (d) begin
              dirty_we = 1'b1;
              dirty_wd = 1'b0;
              res_next = '{bbcc_pkg::KIND_WBACK, cur_slot, tag_q.device, tag_q.block,
                           bbcc_pkg::STAT_OK, 1'b1};
            end
          end
        end else begin
          dirty_we = 1'b1;
          dirty_wd = 1'b1;
        end
      end
      bbcc_pkg::S_SYNC_RD: begin
        state_next = bbcc_pkg::S_SYNC_CMP;
      end
      bbcc_pkg::S_SYNC_CMP: begin
        // hold one write back back so the final one can carry last
        state_next = bbcc_pkg::S_SYNC_NEXT;
        if (v && d && tag_q.device == cur_dev) begin
          dirty_we       = 1'b1;
          dirty_wd       = 1'b0;
          pend_next      = '{bbcc_pkg::KIND_WBACK, 5'(idx), cur_dev, tag_q.block,
                             bbcc_pkg::STAT_OK, 1'b0};
          have_pend_next = 1'b1;
          if (have_pend) begin
            res_next   = pend;
            ret_next   = bbcc_pkg::S_SYNC_NEXT;
            state_next = bbcc_pkg::S_EMIT;
          end
        end
      end
      bbcc_pkg::S_SYNC_NEXT: begin
        if (idx == LAST_IDX) begin
          if (have_pend) begin
            res_next      = pend;
            res_next.last = 1'b1;
          end else begin
            res_next = '{bbcc_pkg::KIND_DONE, 5'd0, 8'd0, 32'd0, bbcc_pkg::STAT_OK, 1'b1};
          end
          ret_next   = bbcc_pkg::S_IDLE;
          state_next = bbcc_pkg::S_EMIT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = bbcc_pkg::S_SYNC_RD;
        end
      end
      bbcc_pkg::S_EMIT: begin
        if (obuf_free) begin
          state_next = ret;
        end
      end
      default: begin
        state_next = bbcc_pkg::S_IDLE;
      end
    endcase
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while previous one in flight");

  a_hand_range: assert property (@(posedge clk) disable iff (rst)
    hand <= LAST_IDX)
    else $error("clock hand out of range");

  a_wrap_bound: assert property (@(posedge clk) disable iff (rst)
    wraps != 2'd3)
    else $error("sweep wrapped too often");

  a_emit_stall: assert property (@(posedge clk) disable iff (rst)
    state == bbcc_pkg::S_EMIT && rsp.valid && !rsp.ready |=> state == bbcc_pkg::S_EMIT)
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

// ===== dv/bbcc_tb_if.sv =====
// testbench build file; holds no interfaces, only the timescale
// depends on nothing; the testbench uses the channel interfaces of the design
`timescale 1ns / 1ps

// ===== dv/block_buffer_cache_clock_policy_core_tb.sv =====
// testbench for the buffer cache clock policy core: random and directed requests,
// a built-in predictor of tags, pins, dirty bits and the clock hand, in-order result checks
// depends on bbcc_pkg and the bbcc_req_if / bbcc_rsp_if interfaces
`timescale 1ns / 1ps

module block_buffer_cache_clock_policy_core_tb;

  localparam int NB = 31;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [2:0]  mode;
    logic [7:0]  device;
    logic [31:0] block;
    logic [4:0]  slot;
  } cache_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bbcc_req_if req_ch ();
  bbcc_rsp_if rsp_ch ();

  block_buffer_cache_clock_policy_core #(.NUM_BUFFERS(NB)) u_top (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // predicted cache state
  bit              tag_valid [NB];
  logic [7:0]      tag_device [NB];
  logic [31:0]     tag_block [NB];
  int              tag_pins [NB];
  bit              tag_dirty [NB];
  int              hand;

  cache_req_t       pending_reqs[$];
  bbcc_pkg::res_t   expected_results[$];
  int               mismatches = 0;
  int               cycle_count = 0;
  int               long_stall = 0;

  function automatic void push_result(logic [1:0] k, int s, logic [7:0] d, logic [31:0] b,
                                      logic [2:0] st, bit l);
    bbcc_pkg::res_t r;
    r.kind = k; r.slot = s[4:0]; r.device = d; r.block = b; r.status = st; r.last = l;
    expected_results.push_back(r);
  endfunction

  function automatic int lookup_tag(logic [7:0] d, logic [31:0] b);
    for (int i = 0; i < NB; i++)
      if (tag_valid[i] && tag_device[i] == d && tag_block[i] == b) return i;
    return -1;
  endfunction

  // clock sweep for a victim; -1 when every entry stays pinned
  function automatic int sweep_victim();
    int wraps;
    wraps = 0;
    forever begin
      hand++;
      if (hand >= NB) begin
        hand = 0;
        wraps++;
        if (wraps > 2) return -1;
      end
      if (tag_pins[hand] < 0) begin
        if (tag_dirty[hand]) begin
          push_result(bbcc_pkg::KIND_WBACK, hand, tag_device[hand], tag_block[hand],
                      bbcc_pkg::STAT_OK, 1'b0);
          tag_dirty[hand] = 1'b0;
        end
        tag_pins[hand] = 1;
        tag_valid[hand] = 1'b0;
        return hand;
      end
      if (tag_pins[hand] == 0) tag_pins[hand] = -1;
    end
  endfunction

  function automatic void predict_cache(cache_req_t q);
    int i, j, n;
    n = 0;
    if (q.mode == bbcc_pkg::MODE_GET || q.mode == bbcc_pkg::MODE_NEW) begin
      if (q.block == 32'd0) begin
        push_result(bbcc_pkg::KIND_DONE, 0, 8'd0, 32'd0, bbcc_pkg::STAT_BLOCK_ZERO, 1'b1);
        return;
      end
      i = lookup_tag(q.device, q.block);
      if (i >= 0) begin
        if (tag_pins[i] < 0) tag_pins[i] = 1;
        else if (tag_pins[i] < 127) tag_pins[i]++;
        if (q.mode == bbcc_pkg::MODE_GET)
          push_result(bbcc_pkg::KIND_DONE, i, 8'd0, 32'd0, bbcc_pkg::STAT_OK, 1'b1);
        else begin
          tag_dirty[i] = 1'b1;
          push_result(bbcc_pkg::KIND_ZERO, i, q.device, q.block, bbcc_pkg::STAT_OK, 1'b1);
        end
        return;
      end
      i = sweep_victim();
      if (i < 0) begin
        push_result(bbcc_pkg::KIND_DONE, 0, 8'd0, 32'd0, bbcc_pkg::STAT_ALL_PINNED, 1'b1);
        return;
      end
      tag_valid[i] = 1'b1; tag_device[i] = q.device; tag_block[i] = q.block;
      tag_dirty[i] = (q.mode == bbcc_pkg::MODE_NEW);
      push_result(q.mode == bbcc_pkg::MODE_GET ? bbcc_pkg::KIND_FILL : bbcc_pkg::KIND_ZERO,
                  i, q.device, q.block, bbcc_pkg::STAT_MISS, 1'b1);
    end else if (q.mode == bbcc_pkg::MODE_RELEASE || q.mode == bbcc_pkg::MODE_DIRTY ||
                 q.mode == bbcc_pkg::MODE_RENAME) begin
      if (q.slot >= NB) begin
        push_result(bbcc_pkg::KIND_DONE, 0, 8'd0, 32'd0, bbcc_pkg::STAT_OK, 1'b1);
        return;
      end
      i = int'(q.slot);
      if (q.mode == bbcc_pkg::MODE_RELEASE) begin
        if (tag_pins[i] <= 0) begin
          push_result(bbcc_pkg::KIND_DONE, i, 8'd0, 32'd0, bbcc_pkg::STAT_UNPINNED, 1'b1);
          return;
        end
        tag_pins[i]--;
        if (tag_dirty[i]) begin
          tag_dirty[i] = 1'b0;
          push_result(bbcc_pkg::KIND_WBACK, i, tag_device[i], tag_block[i],
                      bbcc_pkg::STAT_OK, 1'b1);
        end else push_result(bbcc_pkg::KIND_DONE, i, 8'd0, 32'd0, bbcc_pkg::STAT_OK, 1'b1);
      end else if (q.mode == bbcc_pkg::MODE_DIRTY) begin
        tag_dirty[i] = 1'b1;
        push_result(bbcc_pkg::KIND_DONE, i, 8'd0, 32'd0, bbcc_pkg::STAT_OK, 1'b1);
      end else begin
        j = lookup_tag(q.device, q.block);
        if (j >= 0) begin
          tag_valid[j] = 1'b0;
          tag_pins[j] = 0;
        end
        tag_valid[i] = 1'b1; tag_device[i] = q.device; tag_block[i] = q.block;
        tag_dirty[i] = 1'b1;
        if (tag_pins[i] > -1) tag_pins[i]--;
        push_result(bbcc_pkg::KIND_DONE, i, 8'd0, 32'd0, bbcc_pkg::STAT_OK, 1'b1);
      end
    end else if (q.mode == bbcc_pkg::MODE_SYNC) begin
      for (i = 0; i < NB; i++)
        if (tag_valid[i] && tag_device[i] == q.device && tag_dirty[i]) begin
          tag_dirty[i] = 1'b0;
          push_result(bbcc_pkg::KIND_WBACK, i, q.device, tag_block[i], bbcc_pkg::STAT_OK, 1'b0);
          n++;
        end
      if (n == 0) push_result(bbcc_pkg::KIND_DONE, 0, 8'd0, 32'd0, bbcc_pkg::STAT_OK, 1'b1);
      else expected_results[$].last = 1'b1;
    end else push_result(bbcc_pkg::KIND_DONE, 0, 8'd0, 32'd0, bbcc_pkg::STAT_OK, 1'b1);
  endfunction

  function automatic int gap_length();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(0, 3);
  endfunction

  function automatic void queue_req(logic [2:0] m, logic [7:0] d, logic [31:0] b, logic [4:0] s);
    cache_req_t q;
    q.mode = m; q.device = d; q.block = b; q.slot = s;
    pending_reqs.push_back(q);
  endfunction

  // stimulus: directed corners, then random traffic on a small working set
  initial begin
    logic [2:0] m;
    queue_req(bbcc_pkg::MODE_GET, 8'd0, 32'd0, 5'd0);
    queue_req(bbcc_pkg::MODE_NEW, 8'd255, 32'd0, 5'd31);
    queue_req(bbcc_pkg::MODE_GET, 8'd1, 32'd1, 5'd0);
    queue_req(bbcc_pkg::MODE_GET, 8'd1, 32'd1, 5'd0);
    queue_req(bbcc_pkg::MODE_NEW, 8'd255, 32'hFFFF_FFFF, 5'd0);
    queue_req(bbcc_pkg::MODE_RELEASE, 8'd0, 32'd0, 5'd0);
    queue_req(bbcc_pkg::MODE_RELEASE, 8'd0, 32'd0, 5'd30);
    queue_req(bbcc_pkg::MODE_RELEASE, 8'd0, 32'd0, 5'd31);
    queue_req(bbcc_pkg::MODE_DIRTY, 8'd0, 32'd0, 5'd1);
    queue_req(bbcc_pkg::MODE_DIRTY, 8'd0, 32'd0, 5'd31);
    queue_req(bbcc_pkg::MODE_RENAME, 8'd255, 32'hFFFF_FFFF, 5'd5);
    queue_req(bbcc_pkg::MODE_RENAME, 8'd1, 32'd1, 5'd31);
    queue_req(bbcc_pkg::MODE_SYNC, 8'd255, 32'd0, 5'd0);
    queue_req(bbcc_pkg::MODE_SYNC, 8'd77, 32'd0, 5'd0);
    queue_req(3'd6, 8'd0, 32'd0, 5'd0);
    queue_req(3'd7, 8'hAA, 32'h5555_AAAA, 5'd21);
    // pin every entry so the sweep gives up
    for (int i = 0; i < 33; i++) queue_req(bbcc_pkg::MODE_GET, 8'd9, 32'd100 + i, 5'd0);
    for (int i = 0; i < 31; i++) queue_req(bbcc_pkg::MODE_RELEASE, 8'd0, 32'd0, i[4:0]);
    for (int i = 0; i < 70; i++) begin
      m = 3'($urandom_range(0, 9) < 9 ? $urandom_range(0, 5) : $urandom_range(6, 7));
      if ($urandom_range(0, 4) == 0)
        queue_req(m, 8'($urandom), $urandom, 5'($urandom));
      else
        queue_req(m, 8'($urandom_range(0, 3)), 32'($urandom_range(0, 40)),
                  5'($urandom_range(0, 31)));
      if (i == 60) queue_req(bbcc_pkg::MODE_SYNC, 8'd0, 32'd0, 5'd0);
    end
  end

  // request driver
  int send_gap = 0;
  int sent = 0;
  always @(posedge clk) begin
    cache_req_t q;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.mode <= '0; req_ch.device <= '0;
      req_ch.block_number <= '0; req_ch.buffer_slot <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        q = pending_reqs.pop_front();
        predict_cache(q);
        sent++;
        send_gap = gap_length();
      end
      // drain pause once the stream is partly through
      if (req_ch.valid && !req_ch.ready) begin
        // keep offering the current request
      end else if (pending_reqs.size() != 0 && send_gap == 0 && !(sent == 90 &&
                   expected_results.size() != 0)) begin
        req_ch.valid <= 1'b1;
        req_ch.mode <= pending_reqs[0].mode;
        req_ch.device <= pending_reqs[0].device;
        req_ch.block_number <= pending_reqs[0].block;
        req_ch.buffer_slot <= pending_reqs[0].slot;
      end else begin
        req_ch.valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end
    end
  end

  // long hold-off of the result side
  always @(posedge clk) begin
    if (rst) long_stall <= 0;
    else if (sent == 20 && long_stall == 0) long_stall <= 600;
    else if (long_stall > 1) long_stall <= long_stall - 1;
  end

  // result monitor and ready generation
  int rsp_gap = 0;
  always @(posedge clk) begin
    bbcc_pkg::res_t got, want;
    if (rst) rsp_ch.ready <= 1'b0;
    else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.kind = rsp_ch.kind; got.slot = rsp_ch.slot; got.device = rsp_ch.out_device;
        got.block = rsp_ch.out_block; got.status = rsp_ch.status; got.last = rsp_ch.last;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p actual %p", want, got);
          end
        end
        rsp_gap = gap_length();
      end
      if (long_stall > 1) rsp_ch.ready <= 1'b0;
      else if (rsp_gap > 0) begin
        rsp_gap--;
        rsp_ch.ready <= 1'b0;
      end else rsp_ch.ready <= 1'b1;
    end
  end

  // reset, end of run and timeout
  initial begin
    for (int i = 0; i < NB; i++) begin
      tag_valid[i] = 0; tag_device[i] = 0; tag_block[i] = 0; tag_pins[i] = 0; tag_dirty[i] = 0;
    end
    hand = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    #1;
    while (pending_reqs.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
sv/bbcc_pkg.sv
sv/bbcc_if.sv
sv/bbcc_tag_store.sv
sv/block_buffer_cache_clock_policy_core.sv
dv/bbcc_tb_if.sv
dv/block_buffer_cache_clock_policy_core_tb.sv
